// ===== sv/ordered_byte_list_engine_core_assert.svh =====
// ----------------------------------------------------------------------------
// ordered_byte_list_engine_core_assert.svh
// Assertion macros used by the checker file of the ordered byte list core.
// ----------------------------------------------------------------------------
`ifndef ORDERED_BYTE_LIST_ENGINE_CORE_ASSERT_SVH
`define ORDERED_BYTE_LIST_ENGINE_CORE_ASSERT_SVH

// Checked only while out of reset.
`define OBL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define OBL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/obl_pkg.sv =====
// ----------------------------------------------------------------------------
// obl_pkg
// Types and constants of the ordered byte list core.
// ----------------------------------------------------------------------------
package obl_pkg;

  localparam int CMD_W = 3;
  localparam int VAL_W = 8;
  localparam int POS_W = 10;
  localparam int STS_W = 2;
  localparam int FP_W  = 8;
  localparam int CNT_W = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND     = 3'd0,
    CMD_INSERT     = 3'd1,
    CMD_REMOVE_VAL = 3'd2,
    CMD_REMOVE_AT  = 3'd3,
    CMD_READ_AT    = 3'd4,
    CMD_FIND       = 3'd5,
    CMD_CLEAR      = 3'd6
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK   = 2'd0,
    STS_MISS = 2'd1,
    STS_FULL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_RD,
    S_INS_WR,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DEL_RD,
    S_DEL_WR,
    S_READ_WAIT,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RA_PTR_M1,
    RA_PTR,
    RA_PTR_P1,
    RA_POS
  } raddr_sel_t;

  typedef enum logic {
    WA_CNT,
    WA_PTR
  } waddr_sel_t;

  typedef enum logic {
    WD_VALUE,
    WD_RDATA
  } wdata_sel_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_CNT,
    PTR_POS,
    PTR_INC,
    PTR_DEC
  } ptr_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_t;

  // controller -> datapath
  typedef struct packed {
    logic       capture;
    logic       mem_we;
    waddr_sel_t wsel;
    wdata_sel_t dsel;
    logic       mem_re;
    raddr_sel_t rsel;
    ptr_op_t    ptr_op;
    logic       idx_load;
    cnt_op_t    cnt_op;
    logic       sts_set;
    status_t    sts_val;
    logic       fp_set;
    logic       rd_set;
    logic       out_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t cmd;
    logic full;
    logic pos_out;
    logic ptr_eq_idx;
    logic ptr_end;
    logic ptr_last;
    logic match;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== sv/obl_in_if.sv =====
// ----------------------------------------------------------------------------
// obl_in_if
// Command channel of the ordered byte list core.
// ----------------------------------------------------------------------------
interface obl_in_if;
  logic                                valid;
  logic                                ready;
  logic        [obl_pkg::CMD_W-1:0]    cmd;
  logic        [obl_pkg::VAL_W-1:0]    value;
  logic signed [obl_pkg::POS_W-1:0]    position;

  modport source (output valid, output cmd, output value, output position, input ready);
  modport sink   (input valid, input cmd, input value, input position, output ready);
endinterface

// ===== sv/obl_out_if.sv =====
// ----------------------------------------------------------------------------
// obl_out_if
// Result channel of the ordered byte list core.
// ----------------------------------------------------------------------------
interface obl_out_if;
  logic                         valid;
  logic                         ready;
  logic [obl_pkg::STS_W-1:0]    status;
  logic [obl_pkg::VAL_W-1:0]    read_value;
  logic [obl_pkg::FP_W-1:0]     found_position;
  logic [obl_pkg::CNT_W-1:0]    entry_count;

  modport source (output valid, output status, output read_value, output found_position,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input read_value, input found_position,
                  input entry_count, output ready);
endinterface

// ===== sv/obl_ctrl.sv =====
// ----------------------------------------------------------------------------
// obl_ctrl
// Command sequencer: decodes a transaction and steps the shift/scan loops.
// ----------------------------------------------------------------------------
module obl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  obl_pkg::dp_stat_t stat,
  output obl_pkg::dp_cmd_t  cmd
);

  obl_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= obl_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == obl_pkg::S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      obl_pkg::S_IDLE: begin
        if (in_valid) state_nxt = obl_pkg::S_DECODE;
      end
      obl_pkg::S_DECODE: begin
        case (stat.cmd)
          obl_pkg::CMD_INSERT:     state_nxt = stat.full ? obl_pkg::S_DONE : obl_pkg::S_INS_RD;
          obl_pkg::CMD_REMOVE_VAL,
          obl_pkg::CMD_FIND:       state_nxt = obl_pkg::S_SCAN_RD;
          obl_pkg::CMD_REMOVE_AT:  state_nxt = stat.pos_out ? obl_pkg::S_DONE : obl_pkg::S_DEL_RD;
          obl_pkg::CMD_READ_AT:    state_nxt = stat.pos_out ? obl_pkg::S_DONE
                                                            : obl_pkg::S_READ_WAIT;
          default:                 state_nxt = obl_pkg::S_DONE;
        endcase
      end
      obl_pkg::S_INS_RD: begin
        state_nxt = stat.ptr_eq_idx ? obl_pkg::S_DONE : obl_pkg::S_INS_WR;
      end
      obl_pkg::S_INS_WR:   state_nxt = obl_pkg::S_INS_RD;
      obl_pkg::S_SCAN_RD: begin
        state_nxt = stat.ptr_end ? obl_pkg::S_DONE : obl_pkg::S_SCAN_CHK;
      end
      obl_pkg::S_SCAN_CHK: begin
        if (!stat.match) begin
          state_nxt = obl_pkg::S_SCAN_RD;
        end else if (stat.cmd == obl_pkg::CMD_FIND) begin
          state_nxt = obl_pkg::S_DONE;
        end else begin
          state_nxt = obl_pkg::S_DEL_RD;
        end
      end
      obl_pkg::S_DEL_RD: begin
        state_nxt = stat.ptr_last ? obl_pkg::S_DONE : obl_pkg::S_DEL_WR;
      end
      obl_pkg::S_DEL_WR:    state_nxt = obl_pkg::S_DEL_RD;
      obl_pkg::S_READ_WAIT: state_nxt = obl_pkg::S_DONE;
      obl_pkg::S_DONE: begin
        if (stat.out_free) state_nxt = obl_pkg::S_IDLE;
      end
      default: state_nxt = obl_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.wsel     = obl_pkg::WA_PTR;
    cmd.dsel     = obl_pkg::WD_VALUE;
    cmd.rsel     = obl_pkg::RA_PTR;
    cmd.ptr_op   = obl_pkg::PTR_HOLD;
    cmd.cnt_op   = obl_pkg::CNT_HOLD;
    cmd.sts_val  = obl_pkg::STS_OK;
    case (state_r)
      obl_pkg::S_IDLE: begin
        cmd.capture = in_valid;
      end
      obl_pkg::S_DECODE: begin
        case (stat.cmd)
          obl_pkg::CMD_APPEND: begin
            if (stat.full) begin
              cmd.sts_set = 1'b1;
              cmd.sts_val = obl_pkg::STS_FULL;
            end else begin
              cmd.mem_we = 1'b1;
              cmd.wsel   = obl_pkg::WA_CNT;
              cmd.cnt_op = obl_pkg::CNT_INC;
            end
          end
          obl_pkg::CMD_INSERT: begin
            if (stat.full) begin
              cmd.sts_set = 1'b1;
              cmd.sts_val = obl_pkg::STS_FULL;
            end else begin
              cmd.idx_load = 1'b1;
              cmd.ptr_op   = obl_pkg::PTR_CNT;
            end
          end
          obl_pkg::CMD_REMOVE_VAL,
          obl_pkg::CMD_FIND: begin
            cmd.ptr_op = obl_pkg::PTR_ZERO;
          end
          obl_pkg::CMD_REMOVE_AT: begin
            if (stat.pos_out) begin
              cmd.sts_set = 1'b1;
              cmd.sts_val = obl_pkg::STS_MISS;
            end else begin
              cmd.ptr_op = obl_pkg::PTR_POS;
            end
          end
          obl_pkg::CMD_READ_AT: begin
            if (stat.pos_out) begin
              cmd.sts_set = 1'b1;
              cmd.sts_val = obl_pkg::STS_MISS;
            end else begin
              cmd.mem_re = 1'b1;
              cmd.rsel   = obl_pkg::RA_POS;
            end
          end
          obl_pkg::CMD_CLEAR: begin
            cmd.cnt_op = obl_pkg::CNT_CLR;
          end
          default: begin
            cmd.sts_set = 1'b1;
            cmd.sts_val = obl_pkg::STS_MISS;
          end
        endcase
      end
      obl_pkg::S_INS_RD: begin
        // gap has reached the insert point: drop the new byte in
        if (stat.ptr_eq_idx) begin
          cmd.mem_we = 1'b1;
          cmd.cnt_op = obl_pkg::CNT_INC;
        end else begin
          cmd.mem_re = 1'b1;
          cmd.rsel   = obl_pkg::RA_PTR_M1;
        end
      end
      obl_pkg::S_INS_WR: begin
        cmd.mem_we = 1'b1;
        cmd.dsel   = obl_pkg::WD_RDATA;
        cmd.ptr_op = obl_pkg::PTR_DEC;
      end
      obl_pkg::S_SCAN_RD: begin
        if (stat.ptr_end) begin
          cmd.sts_set = 1'b1;
          cmd.sts_val = obl_pkg::STS_MISS;
        end else begin
          cmd.mem_re = 1'b1;
        end
      end
      obl_pkg::S_SCAN_CHK: begin
        if (!stat.match) begin
          cmd.ptr_op = obl_pkg::PTR_INC;
        end else if (stat.cmd == obl_pkg::CMD_FIND) begin
          cmd.fp_set = 1'b1;
        end
      end
      obl_pkg::S_DEL_RD: begin
        if (stat.ptr_last) begin
          cmd.cnt_op = obl_pkg::CNT_DEC;
        end else begin
          cmd.mem_re = 1'b1;
          cmd.rsel   = obl_pkg::RA_PTR_P1;
        end
      end
      obl_pkg::S_DEL_WR: begin
        cmd.mem_we = 1'b1;
        cmd.dsel   = obl_pkg::WD_RDATA;
        cmd.ptr_op = obl_pkg::PTR_INC;
      end
      obl_pkg::S_READ_WAIT: begin
        cmd.rd_set = 1'b1;
      end
      obl_pkg::S_DONE: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
        cmd.capture = 1'b0;
      end
    endcase
  end

endmodule

// ===== sv/obl_dpath.sv =====
// ----------------------------------------------------------------------------
// obl_dpath
// Entry store, count, walk pointer, result fields and output register.
// ----------------------------------------------------------------------------
module obl_dpath #(
  parameter int CAPACITY = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic        [obl_pkg::CMD_W-1:0]  in_cmd,
  input  logic        [obl_pkg::VAL_W-1:0]  in_value,
  input  logic signed [obl_pkg::POS_W-1:0]  in_position,
  input  obl_pkg::dp_cmd_t                  cmd,
  output obl_pkg::dp_stat_t                 stat,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic        [obl_pkg::STS_W-1:0]  out_status,
  output logic        [obl_pkg::VAL_W-1:0]  out_read_value,
  output logic        [obl_pkg::FP_W-1:0]   out_found_position,
  output logic        [obl_pkg::CNT_W-1:0]  out_entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam logic [obl_pkg::CNT_W-1:0] CAP_C = obl_pkg::CNT_W'(CAPACITY);

  logic [obl_pkg::VAL_W-1:0] entry_mem [CAPACITY];

  logic        [obl_pkg::CMD_W-1:0] cmd_r;
  logic        [obl_pkg::VAL_W-1:0] val_r;
  logic signed [obl_pkg::POS_W-1:0] pos_r;
  logic        [obl_pkg::CNT_W-1:0] ptr_r, ptr_nxt;
  logic        [obl_pkg::CNT_W-1:0] idx_r;
  logic        [obl_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic        [obl_pkg::VAL_W-1:0] rdata_r;
  obl_pkg::status_t                 sts_r;
  logic        [obl_pkg::VAL_W-1:0] rd_r;
  logic        [obl_pkg::FP_W-1:0]  fp_r;
  logic                             out_valid_r;

  logic                             pos_neg;
  logic        [obl_pkg::CNT_W-1:0] pos_mag;
  logic        [obl_pkg::CNT_W-1:0] ins_idx;
  logic        [obl_pkg::CNT_W-1:0] ptr_m1, ptr_p1;
  logic        [obl_pkg::CNT_W:0]   ptr_p1_wide;
  logic        [obl_pkg::CNT_W-1:0] raddr_full, waddr_full;
  logic        [obl_pkg::VAL_W-1:0] wdata;

  assign pos_neg     = pos_r[obl_pkg::POS_W-1];
  assign pos_mag     = pos_r[obl_pkg::CNT_W-1:0];
  assign ins_idx     = pos_neg ? '0 : ((pos_mag > cnt_r) ? cnt_r : pos_mag);
  assign ptr_m1      = ptr_r - 1'b1;
  assign ptr_p1_wide = {1'b0, ptr_r} + 1'b1;
  assign ptr_p1      = ptr_p1_wide[obl_pkg::CNT_W-1:0];

  always_comb begin
    case (cmd.rsel)
      obl_pkg::RA_PTR_M1: raddr_full = ptr_m1;
      obl_pkg::RA_PTR:    raddr_full = ptr_r;
      obl_pkg::RA_PTR_P1: raddr_full = ptr_p1;
      obl_pkg::RA_POS:    raddr_full = pos_mag;
      default:            raddr_full = ptr_r;
    endcase
  end

  assign waddr_full = (cmd.wsel == obl_pkg::WA_CNT) ? cnt_r : ptr_r;
  assign wdata      = (cmd.dsel == obl_pkg::WD_RDATA) ? rdata_r : val_r;

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      entry_mem[waddr_full[AW-1:0]] <= wdata;
    end
    if (cmd.mem_re) begin
      rdata_r <= entry_mem[raddr_full[AW-1:0]];
    end
  end

  always_comb begin
    case (cmd.ptr_op)
      obl_pkg::PTR_ZERO: ptr_nxt = '0;
      obl_pkg::PTR_CNT:  ptr_nxt = cnt_r;
      obl_pkg::PTR_POS:  ptr_nxt = pos_mag;
      obl_pkg::PTR_INC:  ptr_nxt = ptr_p1;
      obl_pkg::PTR_DEC:  ptr_nxt = ptr_m1;
      default:           ptr_nxt = ptr_r;
    endcase
  end

  always_comb begin
    case (cmd.cnt_op)
      obl_pkg::CNT_INC: cnt_nxt = cnt_r + 1'b1;
      obl_pkg::CNT_DEC: cnt_nxt = cnt_r - 1'b1;
      obl_pkg::CNT_CLR: cnt_nxt = '0;
      default:          cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.idx_load) begin
      idx_r <= ins_idx;
    end
    if (cmd.capture) begin
      cmd_r <= in_cmd;
      val_r <= in_value;
      pos_r <= in_position;
      sts_r <= obl_pkg::STS_OK;
      rd_r  <= '0;
      fp_r  <= '0;
    end else begin
      if (cmd.sts_set) sts_r <= cmd.sts_val;
      if (cmd.rd_set)  rd_r  <= rdata_r;
      if (cmd.fp_set)  fp_r  <= ptr_r[obl_pkg::FP_W-1:0];
    end
  end

  // output register: the next transaction may start while this one waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status         <= sts_r;
      out_read_value     <= rd_r;
      out_found_position <= fp_r;
      out_entry_count    <= cnt_r;
    end
  end

  assign out_valid = out_valid_r;

  assign stat.cmd        = obl_pkg::cmd_t'(cmd_r);
  assign stat.full       = (cnt_r >= CAP_C);
  assign stat.pos_out    = pos_neg || (pos_mag >= cnt_r);
  assign stat.ptr_eq_idx = (ptr_r == idx_r);
  assign stat.ptr_end    = (ptr_r >= cnt_r);
  assign stat.ptr_last   = (ptr_p1_wide >= {1'b0, cnt_r});
  assign stat.match      = (rdata_r == val_r);
  assign stat.out_free   = !out_valid_r || out_ready;

endmodule

// ===== sv/ordered_byte_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// ordered_byte_list_engine_core
// Bounded ordered byte list with append, insert, remove, read, find and clear.
// ----------------------------------------------------------------------------
// One command is worked at a time; a finished result sits in an output
// register so the next command can be taken while it waits. Insert shifts
// the entries from the insert point up, remove-at shifts the entries after
// the removed one down, and find or remove-by-value scan entries from index
// 0. Every moved or compared entry needs one read of the entry memory and,
// when moved, one write. The memory needs no clearing after reset.
module ordered_byte_list_engine_core #(
  parameter int CAPACITY = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  obl_in_if.sink     in_chan,
  obl_out_if.source  out_chan
);

  obl_pkg::dp_cmd_t  dp_cmd;
  obl_pkg::dp_stat_t dp_stat;

  obl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  obl_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_cmd             (in_chan.cmd),
    .in_value           (in_chan.value),
    .in_position        (in_chan.position),
    .cmd                (dp_cmd),
    .stat               (dp_stat),
    .out_ready          (out_chan.ready),
    .out_valid          (out_chan.valid),
    .out_status         (out_chan.status),
    .out_read_value     (out_chan.read_value),
    .out_found_position (out_chan.found_position),
    .out_entry_count    (out_chan.entry_count)
  );

endmodule

// ===== sv/obl_core_chk.sv =====
// ----------------------------------------------------------------------------
// obl_core_chk
// Port-level checks of the ordered byte list core, bound to the top level.
// ----------------------------------------------------------------------------
`include "ordered_byte_list_engine_core_assert.svh"

module obl_core_chk #(
  parameter int CAPACITY = 256
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [obl_pkg::STS_W-1:0]   out_status,
  input logic [obl_pkg::VAL_W-1:0]   out_read_value,
  input logic [obl_pkg::FP_W-1:0]    out_found_position,
  input logic [obl_pkg::CNT_W-1:0]   out_entry_count
);

  // a stalled result transaction keeps its payload
  `OBL_ASSERT(a_out_hold, (out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_read_value) && $stable(out_found_position) && $stable(out_entry_count)), "result changed while stalled")

  `OBL_ASSERT(a_full_count, (out_valid && out_status == obl_pkg::STS_FULL |-> out_entry_count == obl_pkg::CNT_W'(CAPACITY)), "full status with store not full")

  `OBL_ASSERT(a_count_cap, (out_valid |-> out_entry_count <= obl_pkg::CNT_W'(CAPACITY)), "entry count beyond capacity")

  // read data and found position are only nonzero on success
  `OBL_ASSERT(a_data_ok, (out_valid && (out_read_value != '0 || out_found_position != '0) |-> out_status == obl_pkg::STS_OK), "data reported with failing status")

  `OBL_ASSERT_ALWAYS(a_reset_idle, (!rst_n |=> !out_valid), "result valid right after reset")

endmodule

bind ordered_byte_list_engine_core obl_core_chk #(
  .CAPACITY (CAPACITY)
) u_obl_core_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_chan.valid),
  .out_ready          (out_chan.ready),
  .out_status         (out_chan.status),
  .out_read_value     (out_chan.read_value),
  .out_found_position (out_chan.found_position),
  .out_entry_count    (out_chan.entry_count)
);

// ===== tb/tb_ordered_byte_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// tb_ordered_byte_list_engine_core
// Self-checking bench for the ordered byte list core. A short directed run
// covers the empty store, both insert clamps, out-of-range reads and removes,
// duplicates and clear. Random fill / drain / mixed traffic follows, which
// reaches the full store several times. Every answer is checked against a
// behavioral list copy. Valid and ready throttle at random before the last third.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ordered_byte_list_engine_core;

  localparam int CAPACITY      = 256;
  localparam int RANDOM_ITEMS  = 1400;
  localparam int SETTLE_CYCLES = 20;

  localparam logic [obl_pkg::CMD_W-1:0]        CMD_UNUSED = 3'd7;
  localparam logic signed [obl_pkg::POS_W-1:0] POS_MIN    = 10'sh200;
  localparam logic signed [obl_pkg::POS_W-1:0] POS_MAX    = 10'sh1ff;

  typedef struct packed {
    obl_pkg::status_t          status;
    logic [obl_pkg::VAL_W-1:0] read_value;
    logic [obl_pkg::FP_W-1:0]  found_position;
    logic [obl_pkg::CNT_W-1:0] entry_count;
  } answer_t;

  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_t;

  // Behavioral copy of the list plus the answers still owed by the core.
  class byte_list_mirror;
    logic [obl_pkg::VAL_W-1:0] store [256];
    int                        count;
    int                        capacity;
    int                        errors;
    answer_t                   pending_answers [$];

    function new(int cap);
      capacity = cap;
      count    = 0;
      errors   = 0;
    endfunction

    function int first_index(logic [obl_pkg::VAL_W-1:0] v);
      for (int i = 0; i < count; i++)
        if (store[i] == v) return i;
      return -1;
    endfunction

    function void drop(int idx);
      for (int i = idx; i < count - 1; i++) store[i] = store[i + 1];
      count--;
    endfunction

    function void apply_command(logic [obl_pkg::CMD_W-1:0] c,
                                logic [obl_pkg::VAL_W-1:0] v,
                                logic signed [obl_pkg::POS_W-1:0] p);
      answer_t a;
      int      pos;
      int      hit;
      a   = '0;
      pos = p;
      case (c)
        obl_pkg::CMD_APPEND, obl_pkg::CMD_INSERT: begin
          if (count >= capacity) begin
            a.status = obl_pkg::STS_FULL;
          end else begin
            if (c == obl_pkg::CMD_APPEND || pos > count) pos = count;
            else if (pos < 0) pos = 0;
            for (int i = count; i > pos; i--) store[i] = store[i - 1];
            store[pos] = v;
            count++;
          end
        end
        obl_pkg::CMD_REMOVE_VAL: begin
          hit = first_index(v);
          if (hit < 0) a.status = obl_pkg::STS_MISS;
          else drop(hit);
        end
        obl_pkg::CMD_REMOVE_AT: begin
          if (pos < 0 || pos >= count) a.status = obl_pkg::STS_MISS;
          else drop(pos);
        end
        obl_pkg::CMD_READ_AT: begin
          if (pos < 0 || pos >= count) a.status = obl_pkg::STS_MISS;
          else a.read_value = store[pos];
        end
        obl_pkg::CMD_FIND: begin
          hit = first_index(v);
          if (hit < 0) a.status = obl_pkg::STS_MISS;
          else a.found_position = hit[obl_pkg::FP_W-1:0];
        end
        obl_pkg::CMD_CLEAR: count = 0;
        default:            a.status = obl_pkg::STS_MISS;
      endcase
      a.entry_count = count[obl_pkg::CNT_W-1:0];
      pending_answers.push_back(a);
    endfunction

    function void compare_field(string field, logic [obl_pkg::CNT_W-1:0] want,
                                logic [obl_pkg::CNT_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0h actual %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_answer(answer_t got);
      answer_t want;
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected answer: expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_answers.pop_front();
      compare_field("status", obl_pkg::CNT_W'(want.status), obl_pkg::CNT_W'(got.status));
      compare_field("read_value", obl_pkg::CNT_W'(want.read_value),
                    obl_pkg::CNT_W'(got.read_value));
      compare_field("found_position", obl_pkg::CNT_W'(want.found_position),
                    obl_pkg::CNT_W'(got.found_position));
      compare_field("entry_count", want.entry_count, got.entry_count);
    endfunction
  endclass

  logic            clk   = 1'b0;
  logic            rst_n = 1'b0;
  int              source_idle_pct;
  int              sink_idle_pct;
  byte_list_mirror mirror = new(CAPACITY);

  obl_in_if  in_chan ();
  obl_out_if out_chan ();

  ordered_byte_list_engine_core #(.CAPACITY(CAPACITY)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin : result_sink
    answer_t seen;
    seen = {out_chan.status, out_chan.read_value, out_chan.found_position,
            out_chan.entry_count};
    if (rst_n && out_chan.valid && out_chan.ready) mirror.check_answer(seen);
    out_chan.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Returns at the edge where the transaction is taken; valid stays high
  // unless the next call idles first.
  task automatic send_command(input logic [obl_pkg::CMD_W-1:0] c,
                              input logic [obl_pkg::VAL_W-1:0] v,
                              input logic signed [obl_pkg::POS_W-1:0] p);
    while ($urandom_range(99) < source_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.cmd      <= c;
    in_chan.value    <= v;
    in_chan.position <= p;
    do @(posedge clk); while (!in_chan.ready);
    mirror.apply_command(c, v, p);
  endtask

  // With a nonempty list, half the picks are stored values, so finds and removes hit.
  function automatic logic [obl_pkg::VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (mirror.count > 0 && r < 50) return mirror.store[$urandom_range(mirror.count - 1)];
    if (r < 80) return obl_pkg::VAL_W'($urandom_range(15));
    return obl_pkg::VAL_W'($urandom());
  endfunction

  function automatic logic signed [obl_pkg::POS_W-1:0] pick_position(int span);
    int r;
    r = $urandom_range(99);
    if (r < 80) return obl_pkg::POS_W'($urandom_range(span));
    if (r < 88) return obl_pkg::POS_W'(-int'($urandom_range(512, 1)));
    if (r < 96) return obl_pkg::POS_W'($urandom_range(511, span));
    return obl_pkg::POS_W'($urandom());
  endfunction

  initial begin : stimulus
    traffic_mode_t             mode;
    logic [obl_pkg::CMD_W-1:0] c;
    int                        r;
    int                        span;
    int                        full_hits;
    int                        mix_left;

    in_chan.valid    = 1'b0;
    in_chan.cmd      = '0;
    in_chan.value    = '0;
    in_chan.position = '0;
    source_idle_pct  = 9;
    sink_idle_pct    = 64;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // empty store
    send_command(obl_pkg::CMD_READ_AT, 8'h00, 10'sd0);
    send_command(obl_pkg::CMD_REMOVE_VAL, 8'h00, 10'sd0);
    send_command(obl_pkg::CMD_REMOVE_AT, 8'h00, 10'sd0);
    send_command(obl_pkg::CMD_FIND, 8'h00, 10'sd0);
    send_command(CMD_UNUSED, 8'hff, -10'sd1);
    // builds 5a 00 33 ff a5: both insert clamps plus a mid insert
    send_command(obl_pkg::CMD_APPEND, 8'h00, 10'sd0);
    send_command(obl_pkg::CMD_APPEND, 8'hff, 10'sd0);
    send_command(obl_pkg::CMD_INSERT, 8'h5a, POS_MIN);
    send_command(obl_pkg::CMD_INSERT, 8'ha5, POS_MAX);
    send_command(obl_pkg::CMD_INSERT, 8'h33, 10'sd2);
    send_command(obl_pkg::CMD_READ_AT, 8'h00, 10'sd0);
    send_command(obl_pkg::CMD_READ_AT, 8'h00, 10'sd4);
    send_command(obl_pkg::CMD_READ_AT, 8'h00, 10'sd5);
    send_command(obl_pkg::CMD_READ_AT, 8'h00, -10'sd1);
    send_command(obl_pkg::CMD_FIND, 8'hff, 10'sd0);
    send_command(obl_pkg::CMD_FIND, 8'h11, 10'sd0);
    // duplicate: remove-by-value must take the first copy
    send_command(obl_pkg::CMD_APPEND, 8'hff, 10'sd0);
    send_command(obl_pkg::CMD_REMOVE_VAL, 8'hff, 10'sd0);
    send_command(obl_pkg::CMD_FIND, 8'hff, 10'sd0);
    send_command(obl_pkg::CMD_REMOVE_AT, 8'h00, 10'sd0);
    send_command(obl_pkg::CMD_REMOVE_AT, 8'h00, POS_MAX);
    send_command(obl_pkg::CMD_REMOVE_AT, 8'h00, POS_MIN);
    send_command(obl_pkg::CMD_REMOVE_AT, 8'h00, 10'sd3);
    send_command(obl_pkg::CMD_CLEAR, 8'h00, 10'sd0);
    send_command(obl_pkg::CMD_READ_AT, 8'h00, 10'sd0);

    mode      = MODE_FILL;
    full_hits = 0;
    mix_left  = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        source_idle_pct = 64;
        sink_idle_pct   = 9;
      end
      if (n == 2 * RANDOM_ITEMS / 3) begin
        source_idle_pct = 0;
        sink_idle_pct   = 0;
      end

      r = $urandom_range(99);
      case (mode)
        MODE_FILL: begin
          if (r < 55)      c = obl_pkg::CMD_APPEND;
          else if (r < 90) c = obl_pkg::CMD_INSERT;
          else if (r < 95) c = obl_pkg::CMD_READ_AT;
          else             c = obl_pkg::CMD_FIND;
        end
        MODE_DRAIN: begin
          if (r < 55)      c = obl_pkg::CMD_REMOVE_AT;
          else if (r < 90) c = obl_pkg::CMD_REMOVE_VAL;
          else if (r < 95) c = obl_pkg::CMD_READ_AT;
          else             c = obl_pkg::CMD_FIND;
        end
        default: begin
          if (r < 15)      c = obl_pkg::CMD_APPEND;
          else if (r < 30) c = obl_pkg::CMD_INSERT;
          else if (r < 45) c = obl_pkg::CMD_REMOVE_VAL;
          else if (r < 60) c = obl_pkg::CMD_REMOVE_AT;
          else if (r < 75) c = obl_pkg::CMD_READ_AT;
          else if (r < 94) c = obl_pkg::CMD_FIND;
          else if (r < 97) c = obl_pkg::CMD_CLEAR;
          else             c = CMD_UNUSED;
        end
      endcase

      span = (c == obl_pkg::CMD_INSERT) ? mirror.count
                                        : (mirror.count > 0 ? mirror.count - 1 : 0);
      send_command(c, pick_value(), pick_position(span));

      // stay at full for a few dropped commands before moving on
      case (mode)
        MODE_FILL: begin
          if (mirror.count == CAPACITY) begin
            full_hits++;
            if (full_hits >= 4) begin
              full_hits = 0;
              mix_left  = $urandom_range(80, 20);
              mode      = $urandom_range(1) ? MODE_DRAIN : MODE_MIX;
            end
          end
        end
        MODE_DRAIN: begin
          if (mirror.count == 0) begin
            mix_left = $urandom_range(80, 20);
            mode     = MODE_MIX;
          end
        end
        default: begin
          mix_left--;
          if (mix_left <= 0) mode = MODE_FILL;
        end
      endcase
    end

    in_chan.valid <= 1'b0;
    while (mirror.pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
